// ===== src/set_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// set_pkg: shared types and constants of the Sobel edge threshold block
// Image limits, field widths, register map and the pipeline stage record.
// ----------------------------------------------------------------------------
package set_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;

  localparam int PixW  = 8;
  localparam int ThrW  = 10;
  localparam int SizeW = 12;
  localparam int ColW  = $clog2(MaxWidth);
  // row position runs up to MaxHeight + 2 before it wraps
  localparam int RowW  = $clog2(MaxHeight + 3);
  localparam int AddrW = 4;
  localparam int DataW = 32;
  localparam int MagW  = 2 * PixW + 1;
  localparam int LimW  = 2 * (ThrW + 1);

  localparam logic [ThrW-1:0]  ThrReset    = 10'd125;
  localparam logic [SizeW-1:0] WidthReset  = 12'd512;
  localparam logic [SizeW-1:0] HeightReset = 12'd512;
  localparam logic [PixW-1:0]  PixMax      = 8'd255;

  typedef enum logic [1:0] {
    RegThreshold = 2'd0,
    RegWidth     = 2'd1,
    RegHeight    = 2'd2
  } reg_idx_e;

  typedef logic [PixW-1:0] pix_t;

  // one window column, top to bottom
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  // item record between acceptance and the window stage
  typedef struct packed {
    logic [ColW-1:0] c;
    pix_t            v;
    logic            row_ge1;
    logic            row_ge2;
    logic            col0;
    logic            finish;
    logic            clr_win;
  } s1_t;

endpackage
`default_nettype wire

// ===== src/set_pix_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// set_pix_if: pixel input channel
// Valid/ready channel carrying one grayscale pixel and its pad flag.
// ----------------------------------------------------------------------------
interface set_pix_if import set_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel;
  logic            pad;

  modport source (output valid, output pixel, output pad, input ready);
  modport sink (input valid, input pixel, input pad, output ready);
endinterface
`default_nettype wire

// ===== src/set_res_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// set_res_if: edge result channel
// Valid/ready channel carrying the edge flag, both gradients and last flag.
// ----------------------------------------------------------------------------
interface set_res_if import set_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] edge_res;
  logic [PixW-1:0] grad_x;
  logic [PixW-1:0] grad_y;
  logic            last_pixel;

  modport source (output valid, output edge_res, output grad_x, output grad_y,
                  output last_pixel, input ready);
  modport sink (input valid, input edge_res, input grad_x, input grad_y,
                input last_pixel, output ready);
endinterface
`default_nettype wire

// ===== src/set_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// set_ram: generic single-write, single-read synchronous RAM
// Registered read; a read of the address written in the same cycle
// returns the old contents.
// ----------------------------------------------------------------------------
module set_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/set_grad.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// set_grad: Sobel gradient kernel
// Forms the horizontal and vertical 3x3 Sobel sums of three columns and
// returns their absolute values saturated to 8 bits.
// ----------------------------------------------------------------------------
module set_grad import set_pkg::*; (
  input  wire column_t l_i,
  input  wire column_t m_i,
  input  wire column_t r_i,
  output pix_t         gx_o,
  output pix_t         gy_o
);

  localparam int SumW  = PixW + 2;
  localparam int DiffW = PixW + 3;

  logic [SumW-1:0]         xp, xn, yp, yn;
  logic signed [DiffW-1:0] sx, sy;

  function automatic pix_t abs_sat(input logic signed [DiffW-1:0] d);
    logic signed [DiffW-1:0] a;
    a = (d < 0) ? -d : d;
    if (a[DiffW-1:PixW] != '0) begin
      return PixMax;
    end
    return a[PixW-1:0];
  endfunction

  always_comb begin
    xp = {2'b00, r_i.top} + {1'b0, r_i.mid, 1'b0} + {2'b00, r_i.bot};
    xn = {2'b00, l_i.top} + {1'b0, l_i.mid, 1'b0} + {2'b00, l_i.bot};
    yp = {2'b00, l_i.bot} + {1'b0, m_i.bot, 1'b0} + {2'b00, r_i.bot};
    yn = {2'b00, l_i.top} + {1'b0, m_i.top, 1'b0} + {2'b00, r_i.top};
    sx = $signed({1'b0, xp}) - $signed({1'b0, xn});
    sy = $signed({1'b0, yp}) - $signed({1'b0, yn});
  end

  assign gx_o = abs_sat(sx);
  assign gy_o = abs_sat(sy);

endmodule
`default_nettype wire

// ===== src/sobel_edge_threshold.sv =====
`default_nettype none
// Results: the transaction that completes a window comes image_width+1 items later
//   in the stream; its result then passes the s1, s2 and output registers.
// Throughput: one item per cycle unless the output stalls; the line store is read
//   at accept, written from s1, forwarding when consecutive items share a column.
// Reset: counters, window, valids and registers clear at once; the line store is
//   not cleared, rows above the frame are masked by the row position.
// ----------------------------------------------------------------------------
// sobel_edge_threshold: streaming 3x3 Sobel edge detector with threshold
// Two packed line buffers in one RAM, a 3x3 window, gradient and magnitude
// stages, an output register and an APB register port.
// ----------------------------------------------------------------------------
module sobel_edge_threshold import set_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  set_pix_if.sink               pix_i,
  set_res_if.source             res_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  // ---------------- configuration ----------------
  logic [ThrW-1:0]  thr_q;
  logic [SizeW-1:0] width_q, height_q;
  logic [LimW-1:0]  lim_q, lim_d;
  logic [ThrW:0]    thr1;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= ThrReset;
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegThreshold: thr_q    <= pwdata[ThrW-1:0];
        RegWidth:     width_q  <= pwdata[SizeW-1:0];
        RegHeight:    height_q <= pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegThreshold: prdata = DataW'(thr_q);
      RegWidth:     prdata = DataW'(width_q);
      RegHeight:    prdata = DataW'(height_q);
      default:      prdata = '0;
    endcase
  end

  // (threshold+1)^2, kept in a register off the pixel path
  assign thr1  = {1'b0, thr_q} + 1'b1;
  assign lim_d = LimW'(thr1 * thr1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LimW'((ThrReset + 1) * (ThrReset + 1));
    end else begin
      lim_q <= lim_d;
    end
  end

  // ---------------- clamped frame size ----------------
  logic [ColW:0]   w;
  logic [RowW-1:0] h, h1;

  always_comb begin
    if (width_q == '0) begin
      w = (ColW+1)'(1);
    end else if (32'(width_q) > 32'(MaxWidth)) begin
      w = (ColW+1)'(MaxWidth);
    end else begin
      w = (ColW+1)'(width_q);
    end
    if (height_q == '0) begin
      h = RowW'(1);
    end else if (32'(height_q) > 32'(MaxHeight)) begin
      h = RowW'(MaxHeight);
    end else begin
      h = RowW'(height_q);
    end
    h1 = h + 1'b1;
  end

  // ---------------- handshake ----------------
  logic res_v_q, s2_v_q, s1_v_q;
  logic out_free, s2_free, s1_free, s1_go, accept;

  assign out_free    = !res_v_q || res_o.ready;
  assign s2_free     = !s2_v_q || out_free;
  assign s1_free     = !s1_v_q || s2_free;
  assign s1_go       = s1_v_q && s2_free;
  assign accept      = pix_i.valid && s1_free;
  assign pix_i.ready = s1_free;

  // ---------------- stream position ----------------
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q, row_d, r_a, r_n;
  logic [ColW:0]   c_a, c_n;
  s1_t             s1_d, s1_q;

  always_comb begin
    c_a       = {1'b0, col_q};
    r_a       = row_q;
    s1_d      = '0;
    if (c_a >= w) begin
      c_a = '0;
      r_a = r_a + 1'b1;
    end
    // stale position after a height change restarts the frame
    if (r_a > h1 || (r_a == h1 && c_a != '0)) begin
      r_a          = '0;
      c_a          = '0;
      s1_d.clr_win = 1'b1;
    end
    s1_d.finish  = (r_a == h1) && (c_a == '0);
    s1_d.c       = c_a[ColW-1:0];
    s1_d.row_ge1 = (r_a != '0);
    s1_d.row_ge2 = (r_a >= RowW'(2));
    s1_d.col0    = (c_a == '0);
    s1_d.v       = (pix_i.pad || r_a >= h) ? '0 : pix_i.pixel;

    c_n = c_a + 1'b1;
    r_n = r_a;
    if (s1_d.finish) begin
      c_n = '0;
      r_n = '0;
    end else if (c_n >= w) begin
      c_n = '0;
      r_n = r_a + 1'b1;
    end
    row_d = r_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= c_n[ColW-1:0];
      row_q <= row_d;
    end
  end

  // ---------------- line store ----------------
  // word = {row before previous, previous row}
  logic [2*PixW-1:0] ram_rdata, ram_wdata, raw, fwd_data_q;
  logic              ram_we, fwd_q;
  pix_t              raw_hi, raw_lo;

  set_ram #(
    .Width (2 * PixW),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.c),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (s1_d.c),
    .rdata_o (ram_rdata)
  );

  assign raw       = fwd_q ? fwd_data_q : ram_rdata;
  assign raw_hi    = raw[2*PixW-1:PixW];
  assign raw_lo    = raw[PixW-1:0];
  assign ram_we    = s1_go;
  assign ram_wdata = {raw_lo, s1_q.v};

  // the write of the item ahead lands on the same edge as this read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (accept) begin
      fwd_q <= s1_go && (s1_q.c == s1_d.c);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q       <= s1_d;
      fwd_data_q <= ram_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= 1'b1;
    end else if (s1_go) begin
      s1_v_q <= 1'b0;
    end
  end

  // ---------------- window ----------------
  column_t win1_q, win2_q, win1_d, win2_d;
  column_t base1, base2, col_new, g_r;
  logic    has_res;
  pix_t    gx, gy;

  always_comb begin
    col_new.top = s1_q.row_ge2 ? raw_hi : '0;
    col_new.mid = s1_q.row_ge1 ? raw_lo : '0;
    col_new.bot = s1_q.v;
    base1       = s1_q.clr_win ? '0 : win1_q;
    base2       = s1_q.clr_win ? '0 : win2_q;
    if (s1_q.col0) begin
      // row end: emit the last center of the finished row against the border
      g_r     = '0;
      win1_d  = '0;
      has_res = s1_q.row_ge2;
    end else begin
      g_r     = col_new;
      win1_d  = base2;
      has_res = s1_q.row_ge1;
    end
    win2_d = col_new;
    if (s1_q.finish) begin
      win1_d = '0;
      win2_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win1_q <= '0;
      win2_q <= '0;
    end else if (s1_go) begin
      win1_q <= win1_d;
      win2_q <= win2_d;
    end
  end

  set_grad u_grad (
    .l_i  (base1),
    .m_i  (base2),
    .r_i  (g_r),
    .gx_o (gx),
    .gy_o (gy)
  );

  // ---------------- magnitude stage ----------------
  pix_t           s2_gx_q, s2_gy_q;
  logic           s2_last_q;
  logic [MagW-1:0] mag2;
  logic           is_edge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_free) begin
      s2_v_q <= s1_go && has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free) begin
      s2_gx_q   <= gx;
      s2_gy_q   <= gy;
      s2_last_q <= s1_q.finish;
    end
  end

  assign mag2    = MagW'(s2_gx_q * s2_gx_q) + MagW'(s2_gy_q * s2_gy_q);
  assign is_edge = LimW'(mag2) >= lim_q;

  // ---------------- output register ----------------
  pix_t edge_q, gx_q, gy_q;
  logic last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (out_free) begin
      res_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      edge_q <= is_edge ? PixMax : '0;
      gx_q   <= s2_gx_q;
      gy_q   <= s2_gy_q;
      last_q <= s2_last_q;
    end
  end

  assign res_o.valid      = res_v_q;
  assign res_o.edge_res   = edge_q;
  assign res_o.grad_x     = gx_q;
  assign res_o.grad_y     = gy_q;
  assign res_o.last_pixel = last_q;

`ifndef NO_ASSERTIONS
  a_s1_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> ((ColW+1)'(s1_q.c) < w))
    else $error("window stage column beyond image width");

  a_finish_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s1_d.finish |=> (row_q == '0) && (col_q == '0))
    else $error("flush item did not restart the frame position");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> s1_v_q && s2_v_q && res_v_q)
    else $error("input stalled with a free pipeline slot");
`endif

endmodule
`default_nettype wire

// ===== tb/sobel_edge_threshold_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_threshold_tb: self-checking bench for the Sobel edge threshold block
// Runs a directed table of small frames, then random frames at random sizes and
// thresholds, with gaps on both channels. A per-item model of the window predicts
// each result a directed row does not give, compared field by field with the output.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_tb;
  import set_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit    = 4000;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 8;
  localparam int TailCycles   = 16;
  localparam int RandomItems  = 750;
  localparam int DirRows      = 33;
  localparam int RandMaxWidth = 12;

  typedef struct packed {
    pix_t edge_res;
    pix_t grad_x;
    pix_t grad_y;
    logic last_pixel;
  } edge_result_t;

  typedef struct packed {
    logic         is_cfg;
    reg_idx_e     reg_sel;
    logic [11:0]  value;
    pix_t         px;
    logic         pd;
    logic         typed;
    edge_result_t want;
  } dir_row_t;

  typedef enum int {TexRandom, TexBinary, TexSmooth, TexFaint} texture_e;
  typedef enum int {PhaseFull, PhaseCut, PhaseNoise} phase_e;

  localparam edge_result_t NoEdge     = '0;
  localparam edge_result_t NoEdgeLast = '{edge_res: '0, grad_x: '0, grad_y: '0,
                                          last_pixel: 1'b1};

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  set_pix_if pix_if ();
  set_res_if res_if ();

  sobel_edge_threshold dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // window model state
  pix_t            line_mem [2*MaxWidth];
  column_t         win_l, win_m, win_r;
  int unsigned     col_pos, row_pos;
  logic [ThrW-1:0]  thr_reg;
  logic [SizeW-1:0] wid_reg, hgt_reg;

  edge_result_t pending[$];
  edge_result_t seen_res, want_res;
  dir_row_t     dir_tab [DirRows];

  int   err_count;
  int   quiet_cycles;
  int   items_sent;
  int   smooth_level;
  bit   sender_burst;
  bit   hold_req;

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  function automatic int unsigned clamp_dim(logic [SizeW-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned frame_items();
    int unsigned w, h;
    w = clamp_dim(wid_reg, MaxWidth);
    h = clamp_dim(hgt_reg, MaxHeight);
    return w * h + w + 1;
  endfunction

  function automatic edge_result_t grade_window(column_t l, column_t m, column_t r,
                                                logic fin);
    int sx, sy, ax, ay, mag2, lim;
    edge_result_t res;
    sx = (int'(r.top) + 2 * int'(r.mid) + int'(r.bot))
       - (int'(l.top) + 2 * int'(l.mid) + int'(l.bot));
    sy = (int'(l.bot) + 2 * int'(m.bot) + int'(r.bot))
       - (int'(l.top) + 2 * int'(m.top) + int'(r.top));
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    if (ax > 255) ax = 255;
    if (ay > 255) ay = 255;
    mag2 = ax * ax + ay * ay;
    lim  = (int'(thr_reg) + 1) * (int'(thr_reg) + 1);
    res.edge_res   = (mag2 >= lim) ? PixMax : '0;
    res.grad_x     = pix_t'(ax);
    res.grad_y     = pix_t'(ay);
    res.last_pixel = fin;
    return res;
  endfunction

  // advances the window by one transaction, returns 1 when a result is due
  function automatic bit advance_window(input pix_t px, input logic pd,
                                        output edge_result_t res);
    int unsigned w, h, c, r;
    pix_t        v;
    column_t     fresh;
    logic        fin;
    bit          has;
    w   = clamp_dim(wid_reg, MaxWidth);
    h   = clamp_dim(hgt_reg, MaxHeight);
    c   = col_pos;
    r   = row_pos;
    res = '0;
    has = 1'b0;
    if (c >= w) begin
      c = 0;
      r++;
    end
    // position past the flush item: frame restarts
    if (r > h + 1 || (r == h + 1 && c != 0)) begin
      r = 0;
      c = 0;
      {win_l, win_m, win_r} = '0;
    end
    v = (pd || r >= h) ? '0 : px;
    fresh.top = (r >= 2) ? line_mem[MaxWidth + c] : '0;
    fresh.mid = (r >= 1) ? line_mem[c] : '0;
    fresh.bot = v;
    fin = (r == h + 1 && c == 0);
    if (c == 0) begin
      if (r >= 2) begin
        res = grade_window(win_m, win_r, '0, fin);
        has = 1'b1;
      end
      win_l = '0;
      win_m = '0;
      win_r = fresh;
    end else begin
      win_l = win_m;
      win_m = win_r;
      win_r = fresh;
      if (r >= 1) begin
        res = grade_window(win_l, win_m, win_r, 1'b0);
        has = 1'b1;
      end
    end
    line_mem[MaxWidth + c] = line_mem[c];
    line_mem[c] = v;
    if (fin) begin
      r = 0;
      c = 0;
      {win_l, win_m, win_r} = '0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
    end
    col_pos = c;
    row_pos = r;
    return has;
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 82) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_flow();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(1, 8);
    if (sel < 95) return $urandom_range(9, 40);
    return $urandom_range(100, 300);
  endfunction

  function automatic pix_t make_pixel(texture_e tex);
    case (tex)
      TexRandom: return pix_t'($urandom);
      TexBinary: return $urandom_range(0, 1) ? PixMax : '0;
      TexSmooth: begin
        smooth_level = smooth_level + int'($urandom_range(0, 8)) - 4;
        if (smooth_level < 0) smooth_level = 0;
        if (smooth_level > 255) smooth_level = 255;
        return pix_t'(smooth_level);
      end
      default: return pix_t'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic dir_row_t cfg_row(reg_idx_e sel, logic [11:0] value);
    dir_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.value   = value;
    return row;
  endfunction

  function automatic dir_row_t px_row(pix_t px, logic pd);
    dir_row_t row;
    row    = '0;
    row.px = px;
    row.pd = pd;
    return row;
  endfunction

  function automatic dir_row_t chk_row(pix_t px, logic pd, edge_result_t want);
    dir_row_t row;
    row       = px_row(px, pd);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  // all driving tasks are entered and left at a falling edge
  task automatic send_pixel(pix_t px, logic pd, logic typed = 1'b0,
                            edge_result_t want = '0);
    int gap;
    edge_result_t pred;
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    pix_if.pad   <= pd;
    do @(posedge clk_i); while (!pix_if.ready);
    items_sent++;
    if (advance_window(px, pd, pred)) pending.push_back(typed ? want : pred);
    @(negedge clk_i);
  endtask

  task automatic settle_block();
    pix_if.valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic apb_cycle(reg_idx_e idx, logic wr, logic [DataW-1:0] wdata,
                           output logic [DataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(reg_idx_e idx, logic [DataW-1:0] want);
    logic [DataW-1:0] rd;
    apb_cycle(idx, 1'b0, '0, rd);
    if (rd !== want)
      flag_error($sformatf("register %s read %0h, expected %0h", idx.name(), rd, want));
  endtask

  task automatic set_register(reg_idx_e idx, int unsigned value);
    logic [DataW-1:0] mask, wdata, rd;
    mask  = (idx == RegThreshold) ? 32'h3FF : 32'hFFF;
    // junk above the field must be dropped by the register
    wdata = (value & mask) | ($urandom & ~mask);
    apb_cycle(idx, 1'b1, wdata, rd);
    case (idx)
      RegThreshold: thr_reg = wdata[ThrW-1:0];
      RegWidth:     wid_reg = wdata[SizeW-1:0];
      default:      hgt_reg = wdata[SizeW-1:0];
    endcase
    check_register(idx, wdata & mask);
  endtask

  task automatic configure_frame(int unsigned thr, int unsigned w, int unsigned h);
    settle_block();
    set_register(RegThreshold, thr);
    set_register(RegWidth, w);
    set_register(RegHeight, h);
  endtask

  // image pixels, then the flush items; pad bits and flush content vary
  task automatic feed_frame(int unsigned count, texture_e tex, bit noisy);
    int unsigned w, h, pos;
    w = clamp_dim(wid_reg, MaxWidth);
    h = clamp_dim(hgt_reg, MaxHeight);
    for (pos = 0; pos < count; pos++) begin
      if (noisy) send_pixel(pix_t'($urandom), 1'($urandom_range(0, 1)));
      else if (pos < w * h) send_pixel(make_pixel(tex), $urandom_range(0, 31) == 0);
      else if ($urandom_range(0, 3) == 0) send_pixel(pix_t'($urandom), 1'b0);
      else send_pixel(pix_t'($urandom), 1'b1);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, runs without stalls, and one long hold-off
  initial begin
    int stall_left;
    int flow_left;
    stall_left = 0;
    flow_left  = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (flow_left > 0) flow_left--;
        else begin
          flow_left  = pick_flow();
          stall_left = pick_gap();
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen_res = {res_if.edge_res, res_if.grad_x, res_if.grad_y, res_if.last_pixel};
      if (pending.size() == 0) begin
        flag_error($sformatf("unexpected result: edge %0d gx %0d gy %0d last %0b",
                             seen_res.edge_res, seen_res.grad_x, seen_res.grad_y,
                             seen_res.last_pixel));
      end else begin
        want_res = pending.pop_front();
        if (seen_res.edge_res !== want_res.edge_res || seen_res.grad_x !== want_res.grad_x ||
            seen_res.grad_y !== want_res.grad_y ||
            seen_res.last_pixel !== want_res.last_pixel)
          flag_error($sformatf(
            "mismatch (exp/got): edge %0d/%0d gx %0d/%0d gy %0d/%0d last %0b/%0b",
            want_res.edge_res, seen_res.edge_res, want_res.grad_x, seen_res.grad_x,
            want_res.grad_y, seen_res.grad_y, want_res.last_pixel, seen_res.last_pixel));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("timeout: no transaction for %0d cycles", IdleLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int unsigned random_start, sel, thr, w_new, h_new;
    bit          pressure_done;
    phase_e      kind;
    texture_e    tex;

    rst_ni       <= 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.pixel <= '0;
    pix_if.pad   <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    err_count     = 0;
    quiet_cycles  = 0;
    items_sent    = 0;
    smooth_level  = 128;
    sender_burst  = 1'b0;
    hold_req      = 1'b0;
    pressure_done = 1'b0;

    thr_reg = ThrReset;
    wid_reg = WidthReset;
    hgt_reg = HeightReset;
    col_pos = 0;
    row_pos = 0;
    {win_l, win_m, win_r} = '0;
    foreach (line_mem[i]) line_mem[i] = '0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    check_register(RegThreshold, DataW'(ThrReset));
    check_register(RegWidth, DataW'(WidthReset));
    check_register(RegHeight, DataW'(HeightReset));

    dir_tab = '{
      // 3x2 frame of zeros; pads in the image and real pixels in the flush
      cfg_row(RegWidth, 12'd3), cfg_row(RegHeight, 12'd2),
      px_row(8'd0, 1'b0), px_row(8'd255, 1'b1), px_row(8'd0, 1'b0),
      px_row(8'd0, 1'b0), chk_row(8'd0, 1'b1, NoEdge), chk_row(8'd0, 1'b0, NoEdge),
      chk_row(8'd255, 1'b0, NoEdge), chk_row(8'd0, 1'b1, NoEdge),
      chk_row(8'd77, 1'b0, NoEdge), chk_row(8'd0, 1'b1, NoEdgeLast),
      // single bright pixel, threshold too large for any edge
      cfg_row(RegThreshold, 12'd1023), cfg_row(RegHeight, 12'd3),
      px_row(8'd0, 1'b0), px_row(8'd0, 1'b0), px_row(8'd0, 1'b0),
      px_row(8'd0, 1'b0), px_row(8'd255, 1'b0), px_row(8'd0, 1'b0),
      px_row(8'd0, 1'b0), px_row(8'd0, 1'b0), px_row(8'd0, 1'b0),
      px_row(8'hA5, 1'b1), px_row(8'hFF, 1'b1), px_row(8'h00, 1'b1), px_row(8'h5A, 1'b1),
      // zero sizes clamp to a 1x1 frame; threshold zero
      cfg_row(RegWidth, 12'd0), cfg_row(RegHeight, 12'd0), cfg_row(RegThreshold, 12'd0),
      px_row(8'd200, 1'b0), px_row(8'd0, 1'b1), chk_row(8'd0, 1'b1, NoEdgeLast)
    };
    foreach (dir_tab[k]) begin
      if (dir_tab[k].is_cfg) begin
        settle_block();
        set_register(dir_tab[k].reg_sel, dir_tab[k].value);
      end else begin
        send_pixel(dir_tab[k].px, dir_tab[k].pd, dir_tab[k].typed, dir_tab[k].want);
      end
    end

    // a full frame at the widest random size fills every line store column
    // that a later narrowed row can read
    configure_frame($urandom_range(0, 360), RandMaxWidth, 1);
    feed_frame(frame_items(), TexRandom, 1'b0);

    random_start = items_sent;
    while (items_sent - random_start < RandomItems) begin
      sel  = $urandom_range(0, 9);
      kind = (sel == 0) ? PhaseNoise : (sel <= 2) ? PhaseCut : PhaseFull;
      case ($urandom_range(0, 7))
        0:       thr = 0;
        1:       thr = 1023;
        2:       thr = $urandom_range(361, 1023);
        default: thr = $urandom_range(0, 360);
      endcase
      w_new = $urandom_range(1, RandMaxWidth);
      h_new = $urandom_range(1, 8);
      if ($urandom_range(0, 15) == 0) w_new = 0;
      if ($urandom_range(0, 15) == 0) h_new = 0;
      if (!pressure_done && items_sent - random_start >= 200) begin
        kind  = PhaseFull;
        w_new = RandMaxWidth;
        h_new = 8;
      end
      configure_frame(thr, w_new, h_new);
      sender_burst = ($urandom_range(0, 3) == 0);
      tex = texture_e'($urandom_range(0, 3));
      if (!pressure_done && kind == PhaseFull && w_new == RandMaxWidth && h_new == 8) begin
        // sender keeps offering while the output is held off
        sender_burst  = 1'b1;
        hold_req      = 1'b1;
        pressure_done = 1'b1;
      end
      case (kind)
        PhaseCut: begin
          // stop mid-frame, set a width no larger and a new height, then run out
          feed_frame($urandom_range(1, frame_items() - 1), tex, 1'b0);
          settle_block();
          set_register(RegWidth, $urandom_range(1, clamp_dim(wid_reg, MaxWidth)));
          set_register(RegHeight, $urandom_range(1, 9));
          while (col_pos != 0 || row_pos != 0)
            send_pixel(make_pixel(tex), $urandom_range(0, 15) == 0);
        end
        default: feed_frame(frame_items(), tex, kind == PhaseNoise);
      endcase
    end

    settle_block();
    repeat (TailCycles) @(negedge clk_i);
    if (err_count == 0 && pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
